/* src/lac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_pkg
// Shared constants, types and the arctangent table for the local azimuth
// pipeline.
// ----------------------------------------------------------------------------
package lac_pkg;

   // defaults for the top-level parameters
   localparam int COORD_WIDTH_DEF = 32;
   localparam int ANGLE_FRAC_DEF  = 16;

   // fixed arithmetic of the datapath
   localparam int RED_BITS     = 21;             // width of a reduced component
   localparam int ACC_FRAC     = 24;             // fraction bits of the angle accumulator
   localparam int CORDIC_STEPS = 28;
   localparam int NORM_TOP     = 40;             // normalised magnitude lies below 2^NORM_TOP
   localparam int SQRT_STAGES  = RED_BITS;       // one root bit per stage
   localparam int XY_W         = NORM_TOP + 6;   // CORDIC x/y width
   localparam int Z_W          = 34;             // CORDIC angle width
   localparam int WIDE_W       = 64;             // width of the unscaled operands

   // register count from request to finished result
   localparam int PIPE_LAT = 3 + SQRT_STAGES + 5 + CORDIC_STEPS + 1;

   localparam logic signed [Z_W-1:0] Z_FULL = Z_W'(64'd360 << ACC_FRAC);
   localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(64'd180 << ACC_FRAC);

   typedef struct packed {
      logic signed [RED_BITS-1:0] x;
      logic signed [RED_BITS-1:0] y;
      logic signed [RED_BITS-1:0] z;
   } red_vec_type;

   typedef struct packed {
      logic bad;    // no east vector
      logic zero;   // projection vanishes
   } lane_flags_type;

   // atan(2^-i) in units of 2^-24 degree
   function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         0:  v = Z_W'(754974720);
         1:  v = Z_W'(445687602);
         2:  v = Z_W'(235489088);
         3:  v = Z_W'(119537938);
         4:  v = Z_W'(60000934);
         5:  v = Z_W'(30029717);
         6:  v = Z_W'(15018523);
         7:  v = Z_W'(7509720);
         8:  v = Z_W'(3754917);
         9:  v = Z_W'(1877466);
         10: v = Z_W'(938734);
         11: v = Z_W'(469367);
         12: v = Z_W'(234684);
         13: v = Z_W'(117342);
         14: v = Z_W'(58671);
         15: v = Z_W'(29335);
         16: v = Z_W'(14668);
         17: v = Z_W'(7334);
         18: v = Z_W'(3667);
         19: v = Z_W'(1833);
         20: v = Z_W'(917);
         21: v = Z_W'(458);
         22: v = Z_W'(229);
         23: v = Z_W'(115);
         24: v = Z_W'(57);
         25: v = Z_W'(29);
         26: v = Z_W'(14);
         27: v = Z_W'(7);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* src/lac_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_reduce
// Scales one vector down by a common floor shift so that every component
// fits the reduced width, and registers the result.
// ----------------------------------------------------------------------------
module lac_reduce #(
   parameter int COORD_WIDTH = lac_pkg::COORD_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    ce,
   input  logic [COORD_WIDTH-1:0]  vx,
   input  logic [COORD_WIDTH-1:0]  vy,
   input  logic [COORD_WIDTH-1:0]  vz,
   output lac_pkg::red_vec_type    vec_ff
);

   localparam int EXT_W = (COORD_WIDTH > lac_pkg::RED_BITS) ? COORD_WIDTH : lac_pkg::RED_BITS;
   localparam int SH_W  = $clog2(EXT_W);

   logic signed [EXT_W-1:0] ex, ey, ez;
   logic        [EXT_W-2:0] diff;
   logic        [SH_W-1:0]  sh;
   lac_pkg::red_vec_type    vec_in;

   assign ex = EXT_W'(signed'(vx));
   assign ey = EXT_W'(signed'(vy));
   assign ez = EXT_W'(signed'(vz));

   // mark every place where a bit differs from the one above it
   assign diff = (ex[EXT_W-1:1] ^ ex[EXT_W-2:0]) | (ey[EXT_W-1:1] ^ ey[EXT_W-2:0])
               | (ez[EXT_W-1:1] ^ ez[EXT_W-2:0]);

   // take the shift from the highest significant bit of the three
   always_comb begin
      sh = '0;
      for (int j = lac_pkg::RED_BITS - 1; j < EXT_W - 1; j++) begin
         if (diff[j]) begin
            sh = SH_W'(j - (lac_pkg::RED_BITS - 2));
         end
      end
      vec_in.x = lac_pkg::RED_BITS'(ex >>> sh);
      vec_in.y = lac_pkg::RED_BITS'(ey >>> sh);
      vec_in.z = lac_pkg::RED_BITS'(ez >>> sh);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         vec_ff <= vec_in;
      end
   end

endmodule

/* src/lac_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module lac_isqrt (
   input  logic                              clock,
   input  logic                              ce,
   input  logic [2*lac_pkg::RED_BITS-1:0]    radicand,
   output logic [lac_pkg::RED_BITS-1:0]      root
);

   localparam int NB  = lac_pkg::RED_BITS;
   localparam int RW  = NB + 2;
   localparam int CW  = NB + 4;
   localparam int N   = lac_pkg::SQRT_STAGES;

   logic [RW-1:0]   rem_ff [N];
   logic [NB-1:0]   q_ff   [N];
   logic [2*NB-1:0] rad_ff [N];

   genvar k;
   for (k = 0; k < N; k++) begin : g_stage
      logic [RW-1:0]   rin;
      logic [NB-1:0]   qin;
      logic [2*NB-1:0] din;
      logic [CW-1:0]   cand, trial;
      logic [RW-1:0]   rem_in;
      logic [NB-1:0]   q_in;

      if (k == 0) begin : g_first
         assign rin = '0;
         assign qin = '0;
         assign din = radicand;
      end else begin : g_next
         assign rin = rem_ff[k-1];
         assign qin = q_ff[k-1];
         assign din = rad_ff[k-1];
      end

      // bring down two bits and try the next root bit
      always_comb begin
         cand  = {rin, din[2*NB-1:2*NB-2]};
         trial = CW'({qin, 2'b01});
         if (cand >= trial) begin
            rem_in = RW'(cand - trial);
            q_in   = {qin[NB-2:0], 1'b1};
         end else begin
            rem_in = RW'(cand);
            q_in   = {qin[NB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[k] <= rem_in;
            q_ff[k]   <= q_in;
            rad_ff[k] <= {din[2*NB-3:0], 2'b00};
         end
      end
   end

   assign root = q_ff[N-1];

endmodule

/* src/lac_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_lane
// One direction's azimuth: east and north components, operand scaling,
// CORDIC vectoring and the fold and round to the output angle.
// ----------------------------------------------------------------------------
module lac_lane #(
   parameter int ANGLE_FRAC_BITS = lac_pkg::ANGLE_FRAC_DEF
) (
   input  logic                               clock,
   input  logic                               ce,
   input  lac_pkg::red_vec_type               dir,        // reduced direction
   input  lac_pkg::red_vec_type               nrm,        // reduced normal
   input  logic [2*lac_pkg::RED_BITS-1:0]     r2,         // nx^2 + ny^2, aligned with dz3_ff
   input  logic                               basis_bad,  // aligned with r2
   input  logic [lac_pkg::RED_BITS-1:0]       mag,        // floor(|n|), from the root pipe
   output logic [9+ANGLE_FRAC_BITS-1:0]       az_ff,
   output lac_pkg::lane_flags_type            flags_ff
);

   localparam int RB    = lac_pkg::RED_BITS;
   localparam int PW    = 2 * RB;
   localparam int SW    = 2 * RB + 1;
   localparam int WW    = lac_pkg::WIDE_W;
   localparam int XW    = lac_pkg::XY_W;
   localparam int ZW    = lac_pkg::Z_W;
   localparam int AZ_W  = 9 + ANGLE_FRAC_BITS;
   localparam int RSH   = lac_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int RHALF = (RSH > 0) ? (1 << (RSH - 1)) : 0;
   localparam int DLY   = lac_pkg::SQRT_STAGES - 2;
   localparam int NS    = lac_pkg::CORDIC_STEPS;
   localparam logic [AZ_W-1:0] AZ_TOP = AZ_W'(64'd360 << ANGLE_FRAC_BITS);

   // pairwise products
   logic signed [PW-1:0] pxx_in, pyy_in, pyx_in, pxy_in, pyz_in, pzy_in, pzx_in, pxz_in;
   logic signed [PW-1:0] pxx_ff, pyy_ff, pyx_ff, pxy_ff, pyz_ff, pzy_ff, pzx_ff, pxz_ff;
   logic signed [RB-1:0] dz2_ff, nz2_ff;

   assign pxx_in = dir.x * nrm.x;
   assign pyy_in = dir.y * nrm.y;
   assign pyx_in = dir.y * nrm.x;
   assign pxy_in = dir.x * nrm.y;
   assign pyz_in = dir.y * nrm.z;
   assign pzy_in = dir.z * nrm.y;
   assign pzx_in = dir.z * nrm.x;
   assign pxz_in = dir.x * nrm.z;

   always_ff @(posedge clock) begin
      if (ce) begin
         pxx_ff <= pxx_in;
         pyy_ff <= pyy_in;
         pyx_ff <= pyx_in;
         pxy_ff <= pxy_in;
         pyz_ff <= pyz_in;
         pzy_ff <= pzy_in;
         pzx_ff <= pzx_in;
         pxz_ff <= pxz_in;
         dz2_ff <= dir.z;
         nz2_ff <= nrm.z;
      end
   end

   // east sine term, partial dot product, parallel test via the cross product
   logic signed [SW-1:0] s3_ff, dnxy3_ff;
   logic signed [RB-1:0] dz3_ff, nz3_ff;
   logic                 zero3_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         s3_ff    <= SW'(pyx_ff) - SW'(pxy_ff);
         dnxy3_ff <= SW'(pxx_ff) + SW'(pyy_ff);
         zero3_ff <= (pyz_ff == pzy_ff) && (pzx_ff == pxz_ff) && (pyx_ff == pxy_ff);
         dz3_ff   <= dz2_ff;
         nz3_ff   <= nz2_ff;
      end
   end

   // north term products
   logic signed [SW-1:0]  r2s;
   logic signed [WW-1:0]  p1_in, p2_in, p1_ff, p2_ff;
   logic signed [SW-1:0]  s4_ff;
   lac_pkg::lane_flags_type f4_ff;

   assign r2s   = signed'({1'b0, r2});
   assign p1_in = dz3_ff * r2s;
   assign p2_in = nz3_ff * dnxy3_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         p1_ff      <= p1_in;
         p2_ff      <= p2_in;
         s4_ff      <= s3_ff;
         f4_ff.zero <= zero3_ff;
         f4_ff.bad  <= basis_bad;
      end
   end

   logic signed [WW-1:0]    c5_ff;
   logic signed [SW-1:0]    s5_ff;
   lac_pkg::lane_flags_type f5_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         c5_ff <= p1_ff - p2_ff;
         s5_ff <= s4_ff;
         f5_ff <= f4_ff;
      end
   end

   // hold the terms until the root of n.n arrives
   logic signed [WW-1:0]    c_dl_ff [DLY];
   logic signed [SW-1:0]    s_dl_ff [DLY];
   lac_pkg::lane_flags_type f_dl_ff [DLY];

   always_ff @(posedge clock) begin
      if (ce) begin
         c_dl_ff[0] <= c5_ff;
         s_dl_ff[0] <= s5_ff;
         f_dl_ff[0] <= f5_ff;
         for (int k = 1; k < DLY; k++) begin
            c_dl_ff[k] <= c_dl_ff[k-1];
            s_dl_ff[k] <= s_dl_ff[k-1];
            f_dl_ff[k] <= f_dl_ff[k-1];
         end
      end
   end

   // east scaled by the normal's length
   logic signed [RB:0]      mag_s;
   logic signed [WW-1:0]    y25_in, y25_ff, x25_ff;
   lac_pkg::lane_flags_type f25_ff;

   assign mag_s  = signed'({1'b0, mag});
   assign y25_in = mag_s * s_dl_ff[DLY-1];

   always_ff @(posedge clock) begin
      if (ce) begin
         y25_ff <= y25_in;
         x25_ff <= c_dl_ff[DLY-1];
         f25_ff <= f_dl_ff[DLY-1];
      end
   end

   // larger magnitude of the pair
   logic [WW-1:0]           ax, ay, mx_ff;
   logic signed [WW-1:0]    x26_ff, y26_ff;
   lac_pkg::lane_flags_type f26_ff;

   assign ax = x25_ff[WW-1] ? WW'(-x25_ff) : WW'(x25_ff);
   assign ay = y25_ff[WW-1] ? WW'(-y25_ff) : WW'(y25_ff);

   always_ff @(posedge clock) begin
      if (ce) begin
         mx_ff  <= (ax > ay) ? ax : ay;
         x26_ff <= x25_ff;
         y26_ff <= y25_ff;
         f26_ff <= f25_ff;
      end
   end

   // locate the leading one and derive the scaling shift
   logic [5:0]              lead, amt_in, amt_ff;
   logic                    rt_in, rt_ff;
   logic signed [WW-1:0]    x27_ff, y27_ff;
   lac_pkg::lane_flags_type f27_ff;

   always_comb begin
      lead = '0;
      for (int j = 0; j < WW; j++) begin
         if (mx_ff[j]) begin
            lead = 6'(j);
         end
      end
      if (int'(lead) >= lac_pkg::NORM_TOP) begin
         rt_in  = 1'b1;
         amt_in = 6'(int'(lead) - (lac_pkg::NORM_TOP - 1));
      end else begin
         rt_in  = 1'b0;
         amt_in = 6'((lac_pkg::NORM_TOP - 1) - int'(lead));
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rt_ff  <= rt_in;
         amt_ff <= amt_in;
         x27_ff <= x26_ff;
         y27_ff <= y26_ff;
         f27_ff <= f26_ff;
      end
   end

   // apply the shared scale
   logic signed [XW-1:0]    x28_ff, y28_ff;
   lac_pkg::lane_flags_type f28_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         x28_ff <= rt_ff ? XW'(x27_ff >>> amt_ff) : XW'(x27_ff <<< amt_ff);
         y28_ff <= rt_ff ? XW'(y27_ff >>> amt_ff) : XW'(y27_ff <<< amt_ff);
         f28_ff <= f27_ff;
      end
   end

   // move the vector into the right half plane
   logic signed [XW-1:0]    x29_ff, y29_ff;
   logic signed [ZW-1:0]    z29_ff;
   lac_pkg::lane_flags_type f29_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         if (x28_ff[XW-1]) begin
            x29_ff <= -x28_ff;
            y29_ff <= -y28_ff;
            z29_ff <= lac_pkg::Z_HALF;
         end else begin
            x29_ff <= x28_ff;
            y29_ff <= y28_ff;
            z29_ff <= '0;
         end
         f29_ff <= f28_ff;
      end
   end

   // CORDIC vectoring, one rotation per stage
   logic signed [XW-1:0]    cx_ff [NS];
   logic signed [XW-1:0]    cy_ff [NS];
   logic signed [ZW-1:0]    cz_ff [NS];
   lac_pkg::lane_flags_type cf_ff [NS];

   genvar i;
   for (i = 0; i < NS; i++) begin : g_rot
      logic signed [XW-1:0]    xi, yi, xo, yo;
      logic signed [ZW-1:0]    zi, zo;
      lac_pkg::lane_flags_type fi;

      if (i == 0) begin : g_first
         assign xi = x29_ff;
         assign yi = y29_ff;
         assign zi = z29_ff;
         assign fi = f29_ff;
      end else begin : g_next
         assign xi = cx_ff[i-1];
         assign yi = cy_ff[i-1];
         assign zi = cz_ff[i-1];
         assign fi = cf_ff[i-1];
      end

      always_comb begin
         if (!yi[XW-1]) begin
            xo = xi + (yi >>> i);
            yo = yi - (xi >>> i);
            zo = zi + lac_pkg::atan_deg(i);
         end else begin
            xo = xi - (yi >>> i);
            yo = yi + (xi >>> i);
            zo = zi - lac_pkg::atan_deg(i);
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            cx_ff[i] <= xo;
            cy_ff[i] <= yo;
            cz_ff[i] <= zo;
            cf_ff[i] <= fi;
         end
      end
   end

   // fold into one turn, round to the output scale, drop degenerate cases
   logic signed [ZW-1:0] zt, zr;
   logic [AZ_W-1:0]      az_r, az_in;

   always_comb begin
      zt = cz_ff[NS-1];
      if (zt[ZW-1]) begin
         zt = zt + lac_pkg::Z_FULL;
      end
      if (zt >= lac_pkg::Z_FULL) begin
         zt = zt - lac_pkg::Z_FULL;
      end
      zr   = (zt + ZW'(RHALF)) >>> RSH;
      az_r = zr[AZ_W-1:0];
      if (az_r >= AZ_TOP) begin
         az_r = az_r - AZ_TOP;
      end
      az_in = (cf_ff[NS-1].bad || cf_ff[NS-1].zero) ? '0 : az_r;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         az_ff    <= az_in;
         flags_ff <= cf_ff[NS-1];
      end
   end

endmodule

/* src/local_azimuth_calc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_azimuth_calc
// Spacecraft and sun azimuths in the tangent plane of a surface normal.
// ----------------------------------------------------------------------------
// The block takes one request per clock and returns one result per request,
// in order, after three stages of reduction and norm products, the 21-stage
// square-root pipe, five stages of scaling, 28 CORDIC stages, one rounding
// stage and the result register. Two lanes, craft and sun, run side by side
// and share the normal's reduction and root. The whole pipeline stalls only
// when both the result register and the skid register behind it are full;
// otherwise requests keep flowing while a result waits to be taken.
module local_azimuth_calc #(
   parameter int COORD_WIDTH     = lac_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_FRAC_BITS = lac_pkg::ANGLE_FRAC_DEF
) (
   input  logic clock,
   input  logic reset,
   // request: craft_dir_x, craft_dir_y, craft_dir_z, sun_dir_x, sun_dir_y,
   //          sun_dir_z, normal_x, normal_y, normal_z (lowest first)
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]   req_tdata,
   // result: craft_azimuth, solar_azimuth, basis_degenerate, craft_degenerate,
   //         sun_degenerate (lowest first)
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((2*(9+ANGLE_FRAC_BITS)+3+7)/8)*8-1:0] rsp_tdata
);

   localparam int W      = COORD_WIDTH;
   localparam int RB     = lac_pkg::RED_BITS;
   localparam int AZ_W   = 9 + ANGLE_FRAC_BITS;
   localparam int OUT_W  = ((2 * AZ_W + 3 + 7) / 8) * 8;
   localparam int LAT    = lac_pkg::PIPE_LAT;
   localparam int BAD_BIT = 2 * AZ_W;
   localparam logic [AZ_W-1:0] AZ_TOP = AZ_W'(64'd360 << ANGLE_FRAC_BITS);

   logic ce;

   // reduce the three vectors
   lac_pkg::red_vec_type dc1, ds1, n1;

   lac_reduce #(.COORD_WIDTH(W)) u_red_craft (
      .clock (clock), .ce (ce),
      .vx (req_tdata[0*W +: W]), .vy (req_tdata[1*W +: W]), .vz (req_tdata[2*W +: W]),
      .vec_ff (dc1)
   );

   lac_reduce #(.COORD_WIDTH(W)) u_red_sun (
      .clock (clock), .ce (ce),
      .vx (req_tdata[3*W +: W]), .vy (req_tdata[4*W +: W]), .vz (req_tdata[5*W +: W]),
      .vec_ff (ds1)
   );

   lac_reduce #(.COORD_WIDTH(W)) u_red_nrm (
      .clock (clock), .ce (ce),
      .vx (req_tdata[6*W +: W]), .vy (req_tdata[7*W +: W]), .vz (req_tdata[8*W +: W]),
      .vec_ff (n1)
   );

   // squares of the normal and the basis check
   logic signed [2*RB-1:0] nsq_x_in, nsq_y_in, nsq_z_in;
   logic signed [2*RB-1:0] nsq_x_ff, nsq_y_ff, nsq_z_ff;
   logic                   bad2_ff, bad3_ff;
   logic [2*RB-1:0]        r2_in, r2_ff, nn_in, nn_ff;

   assign nsq_x_in = n1.x * n1.x;
   assign nsq_y_in = n1.y * n1.y;
   assign nsq_z_in = n1.z * n1.z;
   assign r2_in    = unsigned'(nsq_x_ff) + unsigned'(nsq_y_ff);
   assign nn_in    = r2_in + unsigned'(nsq_z_ff);

   always_ff @(posedge clock) begin
      if (ce) begin
         nsq_x_ff <= nsq_x_in;
         nsq_y_ff <= nsq_y_in;
         nsq_z_ff <= nsq_z_in;
         bad2_ff  <= (n1.x == '0) && (n1.y == '0);
         r2_ff    <= r2_in;
         nn_ff    <= nn_in;
         bad3_ff  <= bad2_ff;
      end
   end

   // length of the normal
   logic [RB-1:0] mag;

   lac_isqrt u_isqrt (
      .clock (clock), .ce (ce), .radicand (nn_ff), .root (mag)
   );

   // craft and sun lanes
   logic [AZ_W-1:0]         az_craft, az_sun;
   lac_pkg::lane_flags_type fl_craft, fl_sun;

   lac_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_craft (
      .clock (clock), .ce (ce), .dir (dc1), .nrm (n1), .r2 (r2_ff),
      .basis_bad (bad3_ff), .mag (mag), .az_ff (az_craft), .flags_ff (fl_craft)
   );

   lac_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_sun (
      .clock (clock), .ce (ce), .dir (ds1), .nrm (n1), .r2 (r2_ff),
      .basis_bad (bad3_ff), .mag (mag), .az_ff (az_sun), .flags_ff (fl_sun)
   );

   // request tracking through the pipe
   logic [LAT-1:0] vld_ff, vld_in;
   logic           last_vld;

   assign vld_in   = {vld_ff[LAT-2:0], req_tvalid};
   assign last_vld = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= vld_in;
      end
   end

   // merge the lanes into one result word
   logic [OUT_W-1:0] merged;

   assign merged = OUT_W'({fl_sun.zero, fl_craft.zero, fl_craft.bad, az_sun, az_craft});

   // result register with a skid stage behind it
   logic             out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   logic [OUT_W-1:0] out_data_ff, out_data_in, skid_data_ff, skid_data_in;

   assign ce         = !skid_vld_ff;
   assign req_tready = ce;

   always_comb begin
      out_vld_in   = out_vld_ff;
      out_data_in  = out_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (!out_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in  = last_vld;
            out_data_in = merged;
         end
      end else if (ce && last_vld) begin
         skid_vld_in  = 1'b1;
         skid_data_in = merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   // checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds a result while the result register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(out_vld_ff && !rsp_tready))
      else $error("skid filled while the result register could move");

   a_basis_zero: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_data_ff[BAD_BIT]) |->
         (out_data_ff[AZ_W-1:0] == '0) && (out_data_ff[2*AZ_W-1:AZ_W] == '0))
      else $error("azimuth not zero without an east vector");

   a_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_data_ff[AZ_W-1:0] < AZ_TOP) && (out_data_ff[2*AZ_W-1:AZ_W] < AZ_TOP))
      else $error("azimuth outside one turn");

endmodule

/* dv/tb_local_azimuth_calc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_local_azimuth_calc
// Regression for the local azimuth pipeline. Every request is predicted by an
// independent fixed-point model (reduction, root, scaling, CORDIC and
// rounding). Each result is compared field by field with the oldest
// prediction, under random gaps on the request side and random stalls on the
// result side.
// ----------------------------------------------------------------------------
module tb_local_azimuth_calc;

   localparam int CW      = lac_pkg::COORD_WIDTH_DEF;
   localparam int AF      = lac_pkg::ANGLE_FRAC_DEF;
   localparam int AZ_W    = 9 + AF;
   localparam int REQ_W   = ((9*CW+7)/8)*8;
   localparam int RSP_W   = ((2*AZ_W+3+7)/8)*8;
   localparam int DRAIN   = lac_pkg::PIPE_LAT + 20;
   localparam int N_RAND  = 1500;

   typedef struct packed {
      logic [AZ_W-1:0] craft_az;
      logic [AZ_W-1:0] sun_az;
      logic            basis_deg;
      logic            craft_deg;
      logic            sun_deg;
   } azimuth_type;

   typedef logic signed [CW-1:0] coord_arr_type [9];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;   // craft x,y,z, sun x,y,z, normal x,y,z
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // craft_az, sun_az, basis, craft, sun

   azimuth_type pending_az[$];
   int          fail_count = 0;

   local_azimuth_calc dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   localparam longint ATAN_TAB [28] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
      117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
      115, 57, 29, 14, 7};

   // shift a vector down until every component fits 21 signed bits
   function automatic void shrink_vec(ref longint v[3]);
      int  s;
      bit  ok;
      s = 0;
      while (s < 62) begin
         ok = 1'b1;
         for (int k = 0; k < 3; k++)
            if ((v[k] >>> s) < -(64'sd1 <<< 20) || (v[k] >>> s) >= (64'sd1 <<< 20))
               ok = 1'b0;
         if (ok) break;
         s++;
      end
      for (int k = 0; k < 3; k++) v[k] = v[k] >>> s;
   endfunction

   function automatic longint int_root(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   // atan2(y, x) in degrees, folded into [0,360) and rounded
   function automatic logic [AZ_W-1:0] cordic_azimuth(longint y, longint x);
      longint unsigned m, mx, my, outv;
      longint z, xs, ys;
      int s;
      mx = (x < 0) ? -x : x;
      my = (y < 0) ? -y : y;
      m  = (mx > my) ? mx : my;
      z  = 0;
      if (m >= (64'd1 << 40)) begin
         s = 0;
         while ((m >> s) >= (64'd1 << 40)) s++;
         x = x >>> s;
         y = y >>> s;
      end else begin
         while (m != 0 && m < (64'd1 << 39)) begin
            m <<= 1;
            x *= 2;
            y *= 2;
         end
      end
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 64'sd180 <<< 24;
      end
      for (int i = 0; i < 28; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += ATAN_TAB[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_TAB[i];
         end
      end
      if (z < 0) z += 64'sd360 <<< 24;
      if (z >= (64'sd360 <<< 24)) z -= 64'sd360 <<< 24;
      outv = (longint'(z) + (64'sd1 <<< (24 - AF - 1))) >> (24 - AF);
      if (outv >= (64'd360 << AF)) outv -= 64'd360 << AF;
      return outv[AZ_W-1:0];
   endfunction

   // azimuth of one direction; flags a vanishing projection
   function automatic logic [AZ_W-1:0] lane_azimuth(longint d[3], longint n[3],
                                                    bit no_east, longint mag,
                                                    output logic is_zero);
      longint r2, nn, dn, s, c;
      r2 = n[0]*n[0] + n[1]*n[1];
      nn = r2 + n[2]*n[2];
      dn = d[0]*n[0] + d[1]*n[1] + d[2]*n[2];
      is_zero = 1'b1;
      for (int k = 0; k < 3; k++)
         if (nn*d[k] - dn*n[k] != 0) is_zero = 1'b0;
      if (is_zero || no_east) return '0;
      s = d[1]*n[0] - d[0]*n[1];
      c = d[2]*r2 - n[2]*(d[0]*n[0] + d[1]*n[1]);
      return cordic_azimuth(mag*s, c);
   endfunction

   function automatic azimuth_type predict_azimuth(coord_arr_type c);
      longint dc[3], ds[3], n[3];
      longint mag;
      azimuth_type r;
      for (int k = 0; k < 3; k++) begin
         dc[k] = c[k];
         ds[k] = c[3+k];
         n[k]  = c[6+k];
      end
      shrink_vec(dc);
      shrink_vec(ds);
      shrink_vec(n);
      r.basis_deg = (n[0] == 0 && n[1] == 0);
      mag = int_root(longint'(n[0]*n[0] + n[1]*n[1] + n[2]*n[2]));
      r.craft_az = lane_azimuth(dc, n, r.basis_deg, mag, r.craft_deg);
      r.sun_az   = lane_azimuth(ds, n, r.basis_deg, mag, r.sun_deg);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   task automatic send_request(coord_arr_type c);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      for (int k = 0; k < 9; k++) req_tdata[CW*k +: CW] <= c[k];
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_az.push_back(predict_azimuth(c));
   endtask

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 64)) - 32;
         2: return $signed($urandom) >>> $urandom_range(0, 31);
         default: return $signed($urandom_range(0, 1 << 30)) - (1 << 29);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_extremes();
      coord_arr_type c;
      logic signed [CW-1:0] vals [5];
      vals = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1};
      foreach (vals[i]) begin
         for (int k = 0; k < 9; k++) c[k] = vals[i];
         send_request(c);
      end
      // alternate extremes across fields
      for (int k = 0; k < 9; k++) c[k] = k[0] ? 32'sh7fffffff : 32'sh80000000;
      send_request(c);
      for (int k = 0; k < 9; k++) c[k] = k[0] ? 32'sh80000000 : 32'sh7fffffff;
      send_request(c);
   endtask

   task automatic test_degenerate();
      coord_arr_type c;
      // normal along the pole: no east
      c = '{100, 200, 300, -5, 7, 9, 0, 0, 1 << 30};
      send_request(c);
      c = '{100, 200, 300, -5, 7, 9, 0, 0, -(1 << 30)};
      send_request(c);
      // zero normal: both projections vanish
      c = '{100, 200, 300, -5, 7, 9, 0, 0, 0};
      send_request(c);
      // directions parallel to the normal
      c = '{1000, -2000, 3000, -4000, 8000, -12000, 1 << 20, -(1 << 21), 3 << 20};
      send_request(c);
      // zero directions
      c = '{0, 0, 0, 0, 0, 0, 1 << 29, 1 << 29, 1 << 29};
      send_request(c);
      // cardinal directions on a tilted normal
      c = '{1 << 20, 0, 0, 0, 1 << 20, 0, 1 << 29, 1 << 28, 1 << 29};
      send_request(c);
      c = '{-(1 << 20), 0, 0, 0, -(1 << 20), 0, 1 << 29, 1 << 28, 1 << 29};
      send_request(c);
      c = '{0, 0, 1 << 24, 0, 0, -(1 << 24), 1 << 30, 0, 0};
      send_request(c);
   endtask

   task automatic test_random(int count);
      coord_arr_type c;
      longint f;
      for (int i = 0; i < count; i++) begin
         for (int k = 0; k < 9; k++) c[k] = rand_coord();
         case ($urandom_range(0, 9))
            0: begin c[6] = 0; c[7] = 0; end
            1: begin
               // direction along the normal, scaled
               f = $urandom_range(1, 3);
               for (int k = 0; k < 3; k++) c[k] = c[6+k] >>> f;
            end
            2: for (int k = 0; k < 3; k++) c[3+k] = c[6+k];
            default: ;
         endcase
         send_request(c);
      end
   endtask

   task automatic test_drain_pause();
      coord_arr_type c;
      req_tvalid <= 1'b0;
      wait (pending_az.size() == 0);
      @(posedge clock);
      for (int k = 0; k < 9; k++) c[k] = rand_coord();
      send_request(c);
   endtask

   // ------------------------------------------------------------------------
   // result checker with random stalls
   // ------------------------------------------------------------------------
   initial begin
      int stall;
      azimuth_type got, want;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[2*AZ_W+2:0];
            got = '{craft_az: rsp_tdata[AZ_W-1:0], sun_az: rsp_tdata[2*AZ_W-1:AZ_W],
                    basis_deg: rsp_tdata[2*AZ_W], craft_deg: rsp_tdata[2*AZ_W+1],
                    sun_deg: rsp_tdata[2*AZ_W+2]};
            if (pending_az.size() == 0) begin
               $error("result with no request outstanding");
               fail_count++;
            end else begin
               want = pending_az.pop_front();
               if (got.craft_az !== want.craft_az) begin
                  $error("craft_azimuth: expected %0d, got %0d", want.craft_az, got.craft_az);
                  fail_count++;
               end
               if (got.sun_az !== want.sun_az) begin
                  $error("solar_azimuth: expected %0d, got %0d", want.sun_az, got.sun_az);
                  fail_count++;
               end
               if (got.basis_deg !== want.basis_deg) begin
                  $error("basis_degenerate: expected %0d, got %0d",
                         want.basis_deg, got.basis_deg);
                  fail_count++;
               end
               if (got.craft_deg !== want.craft_deg) begin
                  $error("craft_degenerate: expected %0d, got %0d",
                         want.craft_deg, got.craft_deg);
                  fail_count++;
               end
               if (got.sun_deg !== want.sun_deg) begin
                  $error("sun_degenerate: expected %0d, got %0d",
                         want.sun_deg, got.sun_deg);
                  fail_count++;
               end
            end
            stall = $urandom_range(0, 5);
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_degenerate();
      test_random(N_RAND / 2);
      test_drain_pause();
      test_random(N_RAND / 2);
      req_tvalid <= 1'b0;
      wait (pending_az.size() == 0);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0 && pending_az.size() == 0) begin
         $display("local_azimuth_calc regression: pass");
      end else begin
         $display("local_azimuth_calc regression: fail");
      end
      $finish;
   end

   // hard stop if the pipeline hangs
   initial begin
      #5ms;
      $display("local_azimuth_calc regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
src/lac_pkg.sv
src/lac_reduce.sv
src/lac_isqrt.sv
src/lac_lane.sv
src/local_azimuth_calc.sv
dv/tb_local_azimuth_calc.sv
